// ----- rtl/fpc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fpc_pkg;

    // Fixed field widths
    localparam int PARAM_W  = 17;   // curve parameter t
    localparam int POINT_W  = 16;   // output coordinate
    localparam int CFG_W    = 12;   // control point coordinate
    localparam int CFG_IDX_W = 3;
    localparam int NUM_REGS = 8;
    localparam int COEF_W   = 16;   // polynomial coefficients a, b, c, d

    // Pipeline depth, input register through output register
    localparam int NUM_STAGES = 9;

    // Saturation window on the value before the divide by 6.
    // Lo = 6 * -32768, Hi = 6 * 32768 - 1; offset value is val - Lo.
    localparam int CLAMP_LO   = -196608;
    localparam int CLAMP_HI   = 196607;
    localparam int OFFSET_W   = 19;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX = 19'd393215;

    // floor(x / 6) = (x * DIV6_MUL) >> DIV6_SHIFT, exact for x < 2^19
    localparam int DIV6_MUL_W = 20;
    localparam logic [DIV6_MUL_W-1:0] DIV6_MUL = 20'd699051;
    localparam int DIV6_SHIFT = 22;
    localparam int PROD_W     = OFFSET_W + DIV6_MUL_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_P1_X,
        REG_P1_Y,
        REG_P2_X,
        REG_P2_Y,
        REG_P3_X,
        REG_P3_Y,
        REG_P4_X,
        REG_P4_Y
    } t_reg_idx;

    localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] = '{
        12'd100, 12'd100, 12'd200, 12'd210, 12'd300, 12'd300, 12'd100, 12'd500
    };

    // Per-axis cubic: ((c*t + b*S)*t + a*S^2)*t + d*S^3, d carries the rounding bias
    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
        logic signed [COEF_W-1:0] d;
    } t_coef;

endpackage

`default_nettype wire

// ----- rtl/fpc_coef.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fpc_coef (
    input  wire logic                          i_clk,
    input  wire logic [fpc_pkg::CFG_W-1:0]     i_q1,
    input  wire logic [fpc_pkg::CFG_W-1:0]     i_q2,
    input  wire logic [fpc_pkg::CFG_W-1:0]     i_q3,
    input  wire logic [fpc_pkg::CFG_W-1:0]     i_q4,
    output fpc_pkg::t_coef                     o_coef
);

    localparam int CW = fpc_pkg::COEF_W;
    localparam int PAD = fpc_pkg::COEF_W - fpc_pkg::CFG_W;
    localparam logic signed [CW-1:0] K2 = CW'(2);
    localparam logic signed [CW-1:0] K3 = CW'(3);
    localparam logic signed [CW-1:0] K6 = CW'(6);

    logic signed [CW-1:0] s1, s2, s3, s4;
    fpc_pkg::t_coef n_coef;
    fpc_pkg::t_coef r_coef;

    assign s1 = signed'({{PAD{1'b0}}, i_q1});
    assign s2 = signed'({{PAD{1'b0}}, i_q2});
    assign s3 = signed'({{PAD{1'b0}}, i_q3});
    assign s4 = signed'({{PAD{1'b0}}, i_q4});

    // All results stay within +-(6*4095 + 3), so 16-bit signed math is exact
    always_comb begin
        n_coef.a = K6 * s3 - K2 * s1 - K3 * s2 - s4;
        n_coef.b = K3 * s1 - K6 * s2 + K3 * s3;
        n_coef.c = K3 * s2 - s1 - K3 * s3 + s4;
        n_coef.d = K6 * s2 + K3;
    end

    // Reloaded every cycle; the user must change points only while the pipe is empty, this block does not enforce it
    always_ff @(posedge i_clk) begin
        r_coef <= n_coef;
    end

    assign o_coef = r_coef;

endmodule

`default_nettype wire

// ----- rtl/fpc_axis.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fpc_axis #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic                                 i_clk,
    input  wire logic [fpc_pkg::NUM_STAGES-1:0]       i_adv,
    input  wire logic signed [fpc_pkg::PARAM_W-1:0]   i_curve_param,
    input  wire fpc_pkg::t_coef                       i_coef,
    output logic signed [fpc_pkg::POINT_W-1:0]        o_point
);

    localparam int F   = FRAC_BITS;
    localparam int TW  = fpc_pkg::PARAM_W;
    localparam int CTW = fpc_pkg::COEF_W + TW;
    // u = c*t + b*S
    localparam int UW  = ((F + 15 > 31) ? F + 15 : 31) + 2;
    localparam int MW  = UW + TW;
    // w = u*t + a*S^2
    localparam int WW  = ((UW + 15 > 2 * F + 15) ? UW + 15 : 2 * F + 15) + 2;
    localparam int H   = WW / 2;
    localparam int PHW = WW - H + TW;
    localparam int PLW = H + 1 + TW;
    localparam int PW  = WW + TW;
    localparam int SW  = PW - 3 * F;
    localparam int VW0 = ((SW > fpc_pkg::COEF_W) ? SW : fpc_pkg::COEF_W) + 1;
    localparam int XW  = (VW0 > fpc_pkg::OFFSET_W + 1) ? VW0 : fpc_pkg::OFFSET_W + 1;
    localparam int OW  = fpc_pkg::OFFSET_W;
    localparam int QW  = fpc_pkg::POINT_W;

    logic signed [TW-1:0]  r_t0, r_t1, r_t2, r_t3;
    logic signed [UW-1:0]  r_u;
    logic signed [MW-1:0]  r_m;
    logic signed [WW-1:0]  r_w;
    logic signed [PHW-1:0] r_ph;
    logic signed [PLW-1:0] r_pl;
    logic signed [PW-1:0]  r_p;
    logic [OW-1:0]         r_x;
    logic [fpc_pkg::PROD_W-1:0] r_prod;
    logic signed [QW-1:0]  r_point;

    logic signed [CTW-1:0]  w_ct;
    logic signed [UW-1:0]   n_u;
    logic signed [MW-1:0]   n_m;
    logic signed [WW-1:0]   n_w;
    logic signed [WW-H-1:0] w_hi;
    logic signed [H:0]      w_lo;
    logic signed [PHW-1:0]  n_ph;
    logic signed [PLW-1:0]  n_pl;
    logic signed [PW-1:0]   n_p;
    logic signed [SW-1:0]   w_sh;
    logic signed [XW-1:0]   w_val;
    logic [OW-1:0]          n_x;
    logic [fpc_pkg::PROD_W-1:0] n_prod;
    logic [QW-1:0]          w_q;
    logic signed [QW-1:0]   n_point;

    always_comb begin
        w_ct = i_coef.c * r_t0;
        n_u  = UW'(w_ct) + (UW'(i_coef.b) <<< F);
        n_m  = r_u * r_t1;
        n_w  = WW'(r_m) + (WW'(i_coef.a) <<< (2 * F));

        // w * t as two narrow products: signed high half, unsigned low half
        w_hi = signed'(r_w[WW-1:H]);
        w_lo = signed'({1'b0, r_w[H-1:0]});
        n_ph = w_hi * r_t3;
        n_pl = w_lo * r_t3;
        n_p  = (PW'(r_ph) <<< H) + PW'(r_pl);

        // floor(P / S^3) + d, then clamp into the window that survives saturation
        w_sh  = signed'(r_p[PW-1:3*F]);
        w_val = XW'(w_sh) + XW'(i_coef.d);
        if (w_val > XW'(fpc_pkg::CLAMP_HI)) begin
            n_x = fpc_pkg::OFFSET_MAX;
        end else if (w_val < XW'(fpc_pkg::CLAMP_LO)) begin
            n_x = '0;
        end else begin
            n_x = OW'(w_val - XW'(fpc_pkg::CLAMP_LO));
        end

        n_prod = r_x * fpc_pkg::DIV6_MUL;

        // floor(x/6) - 32768 is the top bit flipped
        w_q     = r_prod[fpc_pkg::DIV6_SHIFT+QW-1:fpc_pkg::DIV6_SHIFT];
        n_point = signed'({~w_q[QW-1], w_q[QW-2:0]});
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_t0 <= i_curve_param;
        end
        if (i_adv[1]) begin
            r_u  <= n_u;
            r_t1 <= r_t0;
        end
        if (i_adv[2]) begin
            r_m  <= n_m;
            r_t2 <= r_t1;
        end
        if (i_adv[3]) begin
            r_w  <= n_w;
            r_t3 <= r_t2;
        end
        if (i_adv[4]) begin
            r_ph <= n_ph;
            r_pl <= n_pl;
        end
        if (i_adv[5]) begin
            r_p <= n_p;
        end
        if (i_adv[6]) begin
            r_x <= n_x;
        end
        if (i_adv[7]) begin
            r_prod <= n_prod;
        end
        if (i_adv[8]) begin
            r_point <= n_point;
        end
    end

    assign o_point = r_point;

endmodule

`default_nettype wire

// ----- rtl/four_point_cubic_curve_eval.sv -----
// Evaluates the cubic through four control points (reached at t = -1, 0, 1, 2)
// for one parameter t per beat, Q.FRAC_BITS signed, and returns (x, y) rounded
// to the nearest integer (halves up) and saturated to signed 16 bits. Throughput
// is one beat per clock while the output is not stalled; output valid rises as the
// beat reaches the last of the nine register stages of the per-axis Horner datapath
// (the first captures the beat at the accepting edge; then three multiply-by-t
// steps, the split wide product, the shift/clamp and the reciprocal divide by 6).
// A stalled output only holds the stages that are full; bubbles collapse.
// Control points are written through the config port (always ready) and must
// only change while no beat is in flight.
`timescale 1ns / 1ps
`default_nettype none

module four_point_cubic_curve_eval #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic signed [fpc_pkg::PARAM_W-1:0]  i_curve_param,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic signed [fpc_pkg::POINT_W-1:0]       o_point_x,
    output logic signed [fpc_pkg::POINT_W-1:0]       o_point_y,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [fpc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [fpc_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int NS = fpc_pkg::NUM_STAGES;

    logic [fpc_pkg::CFG_W-1:0] r_cfg [fpc_pkg::NUM_REGS];
    logic [NS-1:0]             r_vld;
    logic [NS-1:0]             w_adv;
    fpc_pkg::t_coef            w_coef_x;
    fpc_pkg::t_coef            w_coef_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= fpc_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // A stage moves when it is empty or the one after it moves
    always_comb begin
        w_adv[NS-1] = !r_vld[NS-1] || !i_out_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_in_stall  = !w_adv[0];
    assign o_out_valid = r_vld[NS-1];

    fpc_coef u_coef_x (
        .i_clk  (i_clk),
        .i_q1   (r_cfg[fpc_pkg::REG_P1_X]),
        .i_q2   (r_cfg[fpc_pkg::REG_P2_X]),
        .i_q3   (r_cfg[fpc_pkg::REG_P3_X]),
        .i_q4   (r_cfg[fpc_pkg::REG_P4_X]),
        .o_coef (w_coef_x)
    );

    fpc_coef u_coef_y (
        .i_clk  (i_clk),
        .i_q1   (r_cfg[fpc_pkg::REG_P1_Y]),
        .i_q2   (r_cfg[fpc_pkg::REG_P2_Y]),
        .i_q3   (r_cfg[fpc_pkg::REG_P3_Y]),
        .i_q4   (r_cfg[fpc_pkg::REG_P4_Y]),
        .o_coef (w_coef_y)
    );

    fpc_axis #(
        .FRAC_BITS (FRAC_BITS)
    ) u_axis_x (
        .i_clk         (i_clk),
        .i_adv         (w_adv),
        .i_curve_param (i_curve_param),
        .i_coef        (w_coef_x),
        .o_point       (o_point_x)
    );

    fpc_axis #(
        .FRAC_BITS (FRAC_BITS)
    ) u_axis_y (
        .i_clk         (i_clk),
        .i_adv         (w_adv),
        .i_curve_param (i_curve_param),
        .i_coef        (w_coef_y),
        .o_point       (o_point_y)
    );

    // Input only stalls when every stage is full and the output is held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (&r_vld && i_out_stall))
        else $error("input stalled with room in the pipeline");

    // An accepted beat always lands in the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_vld[0])
        else $error("accepted beat lost at pipeline entry");

    // A beat in the next-to-last stage moves into the output register when allowed
    a_reach_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NS-2] && w_adv[NS-1]) |=> o_out_valid)
        else $error("beat dropped before output register");

endmodule

`default_nettype wire

// ----- tb/four_point_cubic_curve_eval_test.sv -----
`timescale 1ns / 1ps

module four_point_cubic_curve_eval_test;
    import fpc_pkg::*;

    localparam int FRAC_BITS   = 14;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 200;

    typedef struct packed {
        logic signed [POINT_W-1:0] x;
        logic signed [POINT_W-1:0] y;
    } t_point;

    // Directed row: point set to load, parameter, and, where typed is set, a
    // hand-written expected point.
    typedef struct packed {
        logic [2:0]                set;
        logic signed [PARAM_W-1:0] t;
        logic                      typed;
        logic signed [POINT_W-1:0] ex;
        logic signed [POINT_W-1:0] ey;
    } t_row;

    // Order per set: p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y
    localparam logic [CFG_W-1:0] POINT_SETS [5][NUM_REGS] = '{
        '{12'd100, 12'd100, 12'd200, 12'd210, 12'd300, 12'd300, 12'd100, 12'd500},
        '{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095},
        '{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0},
        '{12'd0, 12'd4095, 12'd4095, 12'd0, 12'd0, 12'd4095, 12'd4095, 12'd0},
        '{12'd8, 12'd0, 12'd0, 12'd8, 12'd0, 12'd0, 12'd0, 12'd0}
    };

    localparam int NUM_ROWS = 21;
    // 17'h10000 is t = -4, the most negative parameter
    localparam t_row DIR_ROWS [NUM_ROWS] = '{
        '{3'd0, 17'sd0,      1'b1, 16'sd200,   16'sd210},
        '{3'd0, -17'sd16384, 1'b1, 16'sd100,   16'sd100},
        '{3'd0, 17'sd16384,  1'b1, 16'sd300,   16'sd300},
        '{3'd0, 17'sd32768,  1'b1, 16'sd100,   16'sd500},
        '{3'd0, 17'h10000,   1'b0, 16'sd0,     16'sd0},
        '{3'd0, 17'sd65535,  1'b0, 16'sd0,     16'sd0},
        '{3'd0, 17'sd8192,   1'b0, 16'sd0,     16'sd0},
        '{3'd0, 17'sd1,      1'b0, 16'sd0,     16'sd0},
        '{3'd0, -17'sd1,     1'b0, 16'sd0,     16'sd0},
        '{3'd1, 17'h10000,   1'b1, 16'sd4095,  16'sd4095},
        '{3'd1, 17'sd65535,  1'b1, 16'sd4095,  16'sd4095},
        '{3'd1, 17'sd12345,  1'b1, 16'sd4095,  16'sd4095},
        '{3'd2, 17'sd65535,  1'b1, 16'sd0,     16'sd0},
        '{3'd2, 17'h10000,   1'b1, 16'sd0,     16'sd0},
        '{3'd3, 17'h10000,   1'b1, 16'sh8000,  16'sd32767},
        '{3'd3, 17'sd65535,  1'b1, 16'sd32767, 16'sh8000},
        '{3'd3, 17'sd0,      1'b1, 16'sd4095,  16'sd0},
        '{3'd3, 17'sd16384,  1'b1, 16'sd0,     16'sd4095},
        // t = 0.5: x lands on -0.5, y on 4.5, both round up
        '{3'd4, 17'sd8192,   1'b1, 16'sd0,     16'sd5},
        '{3'd4, -17'sd8192,  1'b0, 16'sd0,     16'sd0},
        '{3'd4, 17'sd24576,  1'b0, 16'sd0,     16'sd0}
    };

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic signed [PARAM_W-1:0] i_curve_param;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic signed [POINT_W-1:0] o_point_x;
    logic signed [POINT_W-1:0] o_point_y;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_W-1:0]          i_cfg_data;

    logic [CFG_W-1:0] ctrl_pts [NUM_REGS];
    logic [CFG_W-1:0] rand_pts [NUM_REGS];
    t_point           expected_points [$];
    t_point           oldest_point;
    int               mismatches = 0;
    bit               calm = 1'b0;
    int               gap_odds = 7;

    four_point_cubic_curve_eval #(
        .FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_curve_param(i_curve_param),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_point_x    (o_point_x),
        .o_point_y    (o_point_y),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // One axis: exact cubic over 6 * 2^(3*FRAC_BITS), rounded half up, saturated
    function automatic logic signed [POINT_W-1:0] curve_coord(
        input logic [CFG_W-1:0] q1, input logic [CFG_W-1:0] q2,
        input logic [CFG_W-1:0] q3, input logic [CFG_W-1:0] q4,
        input logic signed [PARAM_W-1:0] t);
        longint k1, k2, k3, k4, cube, quad, lin, base, val, quo;
        logic signed [127:0] tw, sc, acc;
        k1 = q1;
        k2 = q2;
        k3 = q3;
        k4 = q4;
        cube = -k1 + 3 * k2 - 3 * k3 + k4;
        quad = 3 * k1 - 6 * k2 + 3 * k3;
        lin  = -2 * k1 - 3 * k2 + 6 * k3 - k4;
        base = 6 * k2 + 3;      // +3 is the half-up bias after the divide by 6
        tw = t;
        sc = 128'sd1 <<< FRAC_BITS;
        acc = cube * tw + quad * sc;
        acc = acc * tw + lin * sc * sc;
        acc = acc * tw + base * sc * sc * sc;
        acc = acc >>> (3 * FRAC_BITS);
        val = acc[63:0];
        quo = val / 6;
        if (val % 6 != 0 && val < 0)
            quo = quo - 1;
        if (quo > 32767)
            quo = 32767;
        else if (quo < -32768)
            quo = -32768;
        return quo[POINT_W-1:0];
    endfunction

    function automatic t_point curve_point(input logic signed [PARAM_W-1:0] t);
        t_point p;
        p.x = curve_coord(ctrl_pts[REG_P1_X], ctrl_pts[REG_P2_X],
                          ctrl_pts[REG_P3_X], ctrl_pts[REG_P4_X], t);
        p.y = curve_coord(ctrl_pts[REG_P1_Y], ctrl_pts[REG_P2_Y],
                          ctrl_pts[REG_P3_Y], ctrl_pts[REG_P4_Y], t);
        return p;
    endfunction

    function automatic logic signed [PARAM_W-1:0] pick_param();
        int knots [4] = '{-16384, 0, 16384, 32768};
        case ($urandom_range(0, 9))
            0, 1: begin
                return PARAM_W'($urandom_range(0, 17'h1FFFF));
            end
            2: begin
                return PARAM_W'(knots[$urandom_range(0, 3)] + int'($urandom_range(0, 8)) - 4);
            end
            default: begin
                return PARAM_W'(int'($urandom_range(0, 49152)) - 16384);
            end
        endcase
    endfunction

    task automatic send_param(input logic signed [PARAM_W-1:0] t, input logic typed,
                              input t_point typed_point);
        i_in_valid    <= 1'b1;
        i_curve_param <= t;
        do @(posedge i_clk); while (o_in_stall);
        expected_points.push_back(typed ? typed_point : curve_point(t));
    endtask

    task automatic maybe_idle_input();
        if (!calm && $urandom_range(0, gap_odds) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    // Never returns before a clock edge, so valid is never lowered and raised in one step
    task automatic wait_points_out();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_points.size() != 0);
    endtask

    task automatic load_points(input logic [CFG_W-1:0] vals [NUM_REGS]);
        for (int r = 0; r < NUM_REGS; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= t_reg_idx'(r);
            i_cfg_data  <= vals[r];
            do @(posedge i_clk); while (!o_cfg_ready);
            ctrl_pts[r] = vals[r];
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Output-side stall bursts
    always begin
        @(posedge i_clk);
        if (!calm && $urandom_range(0, gap_odds) == 0) begin
            i_out_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_points.size() == 0) begin
                mismatches++;
                $display("%0t: point expected none got (%0d, %0d)",
                         $time, o_point_x, o_point_y);
            end else begin
                oldest_point = expected_points.pop_front();
                if (o_point_x !== oldest_point.x) begin
                    mismatches++;
                    $display("%0t: point_x expected %0d got %0d",
                             $time, oldest_point.x, o_point_x);
                end
                if (o_point_y !== oldest_point.y) begin
                    mismatches++;
                    $display("%0t: point_y expected %0d got %0d",
                             $time, oldest_point.y, o_point_y);
                end
            end
        end
    end

    initial begin
        int cur_set;
        int pick;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_curve_param <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= REG_P1_X;
        i_cfg_data    <= '0;
        for (int r = 0; r < NUM_REGS; r++)
            ctrl_pts[r] = POINT_SETS[0][r];
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset points first, then extreme and half-rounding sets
        cur_set = 0;
        for (int i = 0; i < NUM_ROWS; i++) begin
            if (int'(DIR_ROWS[i].set) != cur_set) begin
                wait_points_out();
                cur_set = DIR_ROWS[i].set;
                load_points(POINT_SETS[cur_set]);
            end
            maybe_idle_input();
            send_param(DIR_ROWS[i].t, DIR_ROWS[i].typed, '{DIR_ROWS[i].ex, DIR_ROWS[i].ey});
        end

        // Random phases, each with fresh control points; the last one runs flat out
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_points_out();
            for (int r = 0; r < NUM_REGS; r++) begin
                pick = $urandom_range(0, 5);
                if (pick == 0)
                    rand_pts[r] = '0;
                else if (pick == 1)
                    rand_pts[r] = '1;
                else
                    rand_pts[r] = CFG_W'($urandom_range(0, 4095));
            end
            load_points(rand_pts);
            calm     = (phase == NUM_PHASES - 1);
            gap_odds = (phase % 2 != 0) ? 3 : 15;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                maybe_idle_input();
                send_param(pick_param(), 1'b0, '0);
            end
        end

        wait_points_out();
        repeat (2 * NUM_STAGES) @(posedge i_clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/fpc_pkg.sv
rtl/fpc_coef.sv
rtl/fpc_axis.sv
rtl/four_point_cubic_curve_eval.sv
tb/four_point_cubic_curve_eval_test.sv
